// ===== sv/rc4kg_pkg.sv =====
// ---------------------------------------------------------------------------
// RC4 keystream generator package
// Shared constants, beat codes and the command and status structs that join
// the controller and the datapath.
// ---------------------------------------------------------------------------
package rc4kg_pkg;

    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int KEY_MAX     = 16;
    localparam int KEY_IDX_W   = $clog2(KEY_MAX);
    localparam int KEY_CNT_W   = $clog2(KEY_MAX + 1);
    localparam int OUT_W       = 2 * BYTE_W;

    localparam logic ACTION_KEY  = 1'b0;
    localparam logic ACTION_DATA = 1'b1;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [TABLE_AW-1:0]  tbl_addr_t;
    typedef logic [KEY_IDX_W-1:0] key_idx_t;
    typedef logic [KEY_CNT_W-1:0] key_cnt_t;

    typedef struct packed {
        logic sched;
        logic init_step;
        logic rd_i;
        logic rd_j;
        logic wr_i;
        logic wr_j;
        logic key_wr;
        logic key_sched;
        logic data_load;
        logic ksa_step;
        logic ksa_done;
        logic out_load;
    } rc4kg_cmd_t;

    typedef struct packed {
        logic n_last;
        logic out_ready;
    } rc4kg_status_t;

endpackage

// ===== sv/rc4_keystream_generator.sv =====
// ---------------------------------------------------------------------------
// RC4 keystream generator
// A key beat other than the last leaves the controller in idle. A data beat
// is accepted in idle; after the three dependent table reads, its result is
// loaded into the output register with the second swap write, once that
// register is free, and no new beat is taken before then. The last key beat
// blocks input through an identity fill of the table and key mixing per entry.
// After reset, input is blocked while the table is filled with the identity.
// ---------------------------------------------------------------------------
module rc4_keystream_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  rc4kg_pkg::byte_t            s_tdata,   // [7:0] data_byte
    input  logic                        s_tlast,   // key_last
    input  logic                        s_tuser,   // [0] action
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rc4kg_pkg::OUT_W-1:0] m_tdata    // [7:0] keystream_byte, [15:8] result_byte
);
    import rc4kg_pkg::*;

    rc4kg_cmd_t    cmd;
    rc4kg_status_t status;

    rc4kg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    rc4kg_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sv/rc4kg_ram.sv =====
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data. A read of the
// address being written returns the old contents.
// ---------------------------------------------------------------------------
module rc4kg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/rc4kg_ctrl.sv =====
// ---------------------------------------------------------------------------
// RC4 controller
// Sequences the identity fill sweep, the key schedule and one generator step
// per data beat, and issues commands to the datapath.
// ---------------------------------------------------------------------------
module rc4kg_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tlast,
    input  logic                   s_tuser,
    input  rc4kg_pkg::rc4kg_status_t status,
    output rc4kg_pkg::rc4kg_cmd_t    cmd
);
    import rc4kg_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   sched_reg;
    logic   sched_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.sched  = sched_reg;
        state_next = state_reg;
        sched_next = sched_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.init_step = 1'b1;
                if (status.n_last) begin
                    state_next = sched_reg ? ST_RD_I : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == ACTION_DATA) begin
                        cmd.data_load = 1'b1;
                        cmd.rd_i      = 1'b1;
                        state_next    = ST_RD_J;
                    end else begin
                        cmd.key_wr = 1'b1;
                        if (s_tlast) begin
                            cmd.key_sched = 1'b1;
                            sched_next    = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                    end
                end
            end
            ST_RD_I: begin
                cmd.rd_i   = 1'b1;
                state_next = ST_RD_J;
            end
            ST_RD_J: begin
                cmd.rd_j   = 1'b1;
                state_next = ST_WR_I;
            end
            ST_WR_I: begin
                cmd.wr_i   = 1'b1;
                state_next = ST_WR_J;
            end
            ST_WR_J: begin
                cmd.wr_j = 1'b1;
                if (sched_reg) begin
                    cmd.ksa_step = 1'b1;
                    if (status.n_last) begin
                        cmd.ksa_done = 1'b1;
                        sched_next   = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_RD_I;
                    end
                end else if (status.out_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            sched_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sched_reg <= sched_next;
        end
    end

    a_one_ram_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.init_step, cmd.rd_i, cmd.rd_j, cmd.wr_i, cmd.wr_j}))
        else $error("more than one table operation in a cycle");

    a_last_key_starts_sched: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == ACTION_KEY && s_tlast)
        |=> (state_reg == ST_CLEAR && sched_reg))
        else $error("last key beat did not start the key schedule");

    a_sched_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ksa_done |=> (state_reg == ST_IDLE && !sched_reg))
        else $error("key schedule did not return to idle");

endmodule

// ===== sv/rc4kg_datapath.sv =====
// ---------------------------------------------------------------------------
// RC4 datapath
// Holds the permutation table, the indices, the key store and the output
// register, and carries out the table reads, swaps and keystream lookup.
// ---------------------------------------------------------------------------
module rc4kg_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rc4kg_pkg::rc4kg_cmd_t    cmd,
    output rc4kg_pkg::rc4kg_status_t status,
    input  rc4kg_pkg::byte_t         s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [rc4kg_pkg::OUT_W-1:0] m_tdata
);
    import rc4kg_pkg::*;

    byte_t     n_reg;
    byte_t     i_reg;
    byte_t     j_reg;
    key_cnt_t  key_count_reg;
    key_cnt_t  key_len_reg;
    key_idx_t  key_idx_reg;
    byte_t     key_store_reg [KEY_MAX];
    byte_t     si_reg;
    byte_t     sj_reg;
    byte_t     t_reg;
    byte_t     data_reg;
    logic      out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    byte_t     key_byte;
    byte_t     i_inc;
    byte_t     j_sum;
    byte_t     t_sum;
    byte_t     cur_idx;
    byte_t     ks;
    key_cnt_t  key_len_next;
    key_cnt_t  key_idx_inc;

    logic      ram_we;
    tbl_addr_t ram_waddr;
    byte_t     ram_wdata;
    logic      ram_re;
    tbl_addr_t ram_raddr;
    byte_t     ram_rdata;

    assign key_byte     = key_store_reg[key_idx_reg];
    assign i_inc        = i_reg + 8'd1;
    assign j_sum        = j_reg + ram_rdata + (cmd.sched ? key_byte : '0);
    assign t_sum        = si_reg + ram_rdata;
    assign cur_idx      = cmd.sched ? n_reg : i_reg;
    assign key_len_next = (key_count_reg < KEY_CNT_W'(KEY_MAX))
                        ? key_count_reg + KEY_CNT_W'(1) : KEY_CNT_W'(KEY_MAX);
    assign key_idx_inc  = {1'b0, key_idx_reg} + KEY_CNT_W'(1);

    // The lookup read is issued before the swap has been written back, so it is
    // stale for the two swapped table entries only, and those two cases are forwarded.
    assign ks = (t_reg == j_reg) ? si_reg :
                (t_reg == i_reg) ? sj_reg : ram_rdata;

    always_comb begin
        ram_we    = cmd.init_step | cmd.wr_i | cmd.wr_j;
        ram_waddr = j_reg;
        ram_wdata = si_reg;
        if (cmd.init_step) begin
            ram_waddr = n_reg;
            ram_wdata = n_reg;
        end else if (cmd.wr_i) begin
            ram_waddr = cur_idx;
            ram_wdata = ram_rdata;
        end
        ram_re    = cmd.rd_i | cmd.rd_j | cmd.wr_i;
        ram_raddr = t_sum;
        if (cmd.rd_i) begin
            ram_raddr = cmd.sched ? n_reg : i_inc;
        end else if (cmd.rd_j) begin
            ram_raddr = j_sum;
        end
    end

    rc4kg_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_perm_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            key_count_reg <= '0;
            key_len_reg   <= KEY_CNT_W'(1);
            key_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.init_step || cmd.ksa_step) begin
                n_reg <= n_reg + 8'd1;
            end
            if (cmd.rd_i && !cmd.sched) begin
                i_reg <= i_inc;
            end
            if (cmd.rd_j) begin
                j_reg <= j_sum;
            end
            if (cmd.ksa_step) begin
                key_idx_reg <= (key_idx_inc == key_len_reg) ? '0
                                                             : key_idx_inc[KEY_IDX_W-1:0];
            end
            if (cmd.ksa_done) begin
                j_reg <= '0;
            end
            if (cmd.key_sched) begin
                key_count_reg <= '0;
            end else if (cmd.key_wr && key_count_reg < KEY_CNT_W'(KEY_MAX)) begin
                key_count_reg <= key_count_reg + KEY_CNT_W'(1);
            end
            if (cmd.key_sched) begin
                key_len_reg   <= key_len_next;
                key_idx_reg   <= '0;
                i_reg         <= '0;
                j_reg         <= '0;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.key_wr && key_count_reg < KEY_CNT_W'(KEY_MAX)) begin
            key_store_reg[key_count_reg[KEY_IDX_W-1:0]] <= s_tdata;
        end
        if (cmd.rd_j) begin
            si_reg <= ram_rdata;
        end
        if (cmd.wr_i) begin
            sj_reg <= ram_rdata;
            t_reg  <= t_sum;
        end
        if (cmd.data_load) begin
            data_reg <= s_tdata;
        end
        if (cmd.out_load) begin
            out_data_reg <= {data_reg ^ ks, ks};
        end
    end

    assign status.n_last    = (n_reg == byte_t'(TABLE_DEPTH - 1));
    assign status.out_ready = !out_valid_reg || m_tready;
    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_data_reg;

    a_key_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        key_count_reg <= KEY_CNT_W'(KEY_MAX))
        else $error("key count beyond key store depth");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a beat not yet taken");

    a_key_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sched |-> (key_len_reg != '0 && key_len_reg <= KEY_CNT_W'(KEY_MAX)))
        else $error("key length out of range during key schedule");

endmodule

// ===== tb/sv/rc4_keystream_generator_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RC4 keystream generator testbench
// Sends key and data beats through the input stream. A behavioral model of
// the cipher predicts the keystream and result byte for each data beat. Each
// output beat is checked against the oldest prediction. Both stream sides are
// throttled at random.
// ---------------------------------------------------------------------------
module rc4_keystream_generator_tb;
    import rc4kg_pkg::*;

    localparam int N_RANDOM_BEATS = 1500;
    localparam int RX_FREE        = 0;
    localparam int RX_RANDOM      = 1;
    localparam int RX_SPARSE      = 2;

    typedef struct {
        logic  action;
        byte_t data;
        logic  last;
        bit    hold;
    } cipher_beat_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    byte_t                s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    cipher_beat_t         beats_to_send [$];
    logic [OUT_W-1:0]     keystream_due [$];

    byte_t                perm_tbl [0:TABLE_DEPTH-1];
    byte_t                key_mem [0:KEY_MAX-1];
    byte_t                gen_i;
    byte_t                gen_j;
    int                   key_len;

    bit                   beat_done  = 1'b0;
    int                   burst_left = 1;
    int                   gap_left   = 0;
    int                   rx_mode    = RX_FREE;
    int                   rx_phase   = 0;
    logic [2:0]           rx_tick    = '0;

    int                   cycles      = 0;
    int                   cycle_limit = 100_000_000;
    int                   mismatches  = 0;
    int                   n_checked   = 0;
    int                   n_key       = 0;
    int                   n_data      = 0;
    int                   n_sched     = 0;

    rc4_keystream_generator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic queue_beat(input logic action, input byte_t data, input logic last,
                              input bit hold = 1'b0);
        cipher_beat_t b;
        b.action = action;
        b.data   = data;
        b.last   = last;
        b.hold   = hold;
        beats_to_send.push_back(b);
        if (action == ACTION_KEY) begin
            n_key++;
            if (last) begin
                n_sched++;
            end
        end else begin
            n_data++;
        end
    endtask

    function automatic void apply_beat(logic action, byte_t data, logic last);
        int    len;
        byte_t j;
        byte_t t;
        byte_t ks;
        if (action == ACTION_KEY) begin
            if (key_len < KEY_MAX) begin
                key_mem[key_len] = data;
                key_len++;
            end
            if (last) begin
                len = (key_len == 0) ? 1 : key_len;
                for (int n = 0; n < TABLE_DEPTH; n++) begin
                    perm_tbl[n] = byte_t'(n);
                end
                j = '0;
                for (int n = 0; n < TABLE_DEPTH; n++) begin
                    j = j + perm_tbl[n] + key_mem[n % len];
                    t = perm_tbl[n];
                    perm_tbl[n] = perm_tbl[j];
                    perm_tbl[j] = t;
                end
                gen_i   = '0;
                gen_j   = '0;
                key_len = 0;
            end
        end else begin
            gen_i = gen_i + 8'd1;
            gen_j = gen_j + perm_tbl[gen_i];
            t = perm_tbl[gen_i];
            perm_tbl[gen_i] = perm_tbl[gen_j];
            perm_tbl[gen_j] = t;
            t  = perm_tbl[gen_i] + perm_tbl[gen_j];
            ks = perm_tbl[t];
            keystream_due.push_back({data ^ ks, ks});
        end
    endfunction

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || beat_done)) begin
            beat_done = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (beats_to_send.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (beats_to_send[0].hold && keystream_due.size() != 0) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tuser  <= beats_to_send[0].action;
                s_tdata  <= beats_to_send[0].data;
                s_tlast  <= beats_to_send[0].last;
                void'(beats_to_send.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_phase == 0) begin
            rx_mode  = $urandom_range(RX_FREE, RX_SPARSE);
            rx_phase = 64;
        end
        rx_phase--;
        rx_tick++;
        case (rx_mode)
            RX_FREE: begin
                m_tready <= 1'b1;
            end
            RX_RANDOM: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= (rx_tick == 3'd0);
            end
        endcase
    end

    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (s_tvalid && s_tready) begin
            apply_beat(s_tuser, s_tdata, s_tlast);
            beat_done = 1'b1;
        end
        if (m_tvalid && m_tready) begin
            n_checked++;
            if (keystream_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: unexpected output beat keystream=%02h result=%02h",
                             m_tdata[7:0], m_tdata[15:8]);
                end
            end else begin
                want = keystream_due.pop_front();
                if (m_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: beat %0d ks exp %02h got %02h, result exp %02h got %02h",
                                 n_checked, want[7:0], m_tdata[7:0], want[15:8], m_tdata[15:8]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > cycle_limit) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("rc4_keystream_generator regression: fail");
            $finish;
        end
    end

    initial begin
        int    start;
        int    klen;
        int    mid;
        int    cnt;
        bit    hold;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            perm_tbl[n] = byte_t'(n);
        end
        gen_i   = '0;
        gen_j   = '0;
        key_len = 0;

        // Directed: data on the identity table, a one-byte key, then an
        // overlong key with a data beat in the middle of the load.
        queue_beat(ACTION_DATA, 8'h00, 1'b0);
        queue_beat(ACTION_DATA, 8'hFF, 1'b1);
        queue_beat(ACTION_DATA, 8'h5A, 1'b0);
        queue_beat(ACTION_KEY,  8'hFF, 1'b1, 1'b1);
        queue_beat(ACTION_DATA, 8'h00, 1'b0);
        for (int k = 0; k < 8; k++) begin
            queue_beat(ACTION_KEY, (k == 0) ? 8'h00 : byte_t'(8'h80 | (k * 17)), 1'b0);
        end
        queue_beat(ACTION_DATA, 8'hFF, 1'b0);
        for (int k = 0; k < 9; k++) begin
            queue_beat(ACTION_KEY, (k == 7) ? 8'hFF : byte_t'(k * 29 + 3), k == 8);
        end
        queue_beat(ACTION_DATA, 8'hA5, 1'b1, 1'b1);

        start = beats_to_send.size();
        while (beats_to_send.size() - start < N_RANDOM_BEATS) begin
            hold = ($urandom_range(0, 24) == 0);
            if ($urandom_range(0, 9) < 8) begin
                klen = ($urandom_range(0, 7) == 0) ? $urandom_range(KEY_MAX + 1, KEY_MAX + 4)
                                                   : $urandom_range(1, KEY_MAX);
                mid  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, klen - 1 + (klen == 1))
                                                   : 0;
                for (int k = 0; k < klen; k++) begin
                    if (k == mid && mid != 0) begin
                        cnt = $urandom_range(1, 3);
                        repeat (cnt) queue_beat(ACTION_DATA, byte_t'($urandom_range(0, 255)),
                                                1'($urandom_range(0, 1)));
                    end
                    queue_beat(ACTION_KEY, byte_t'($urandom_range(0, 255)), k == klen - 1,
                               hold && k == 0);
                end
                cnt = $urandom_range(1, 40);
                repeat (cnt) queue_beat(ACTION_DATA, byte_t'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1)));
            end else begin
                cnt = $urandom_range(1, 10);
                for (int k = 0; k < cnt; k++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        queue_beat(ACTION_KEY, byte_t'($urandom_range(0, 255)),
                                   $urandom_range(0, 7) == 0, hold && k == 0);
                    end else begin
                        queue_beat(ACTION_DATA, byte_t'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)), hold && k == 0);
                    end
                end
            end
        end

        cycle_limit = 4 * (300 + n_sched * 1300 + (n_key + n_data) * 20 + n_data * 16)
                      + 20_000;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (beats_to_send.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (keystream_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);

        if (keystream_due.size() != 0) begin
            mismatches += keystream_due.size();
        end
        $display("Sent %0d key beats and %0d data beats, ran %0d key schedules.",
                 n_key, n_data, n_sched);
        $display("Checked %0d output beats in %0d cycles, %0d mismatches.",
                 n_checked, cycles, mismatches);
        if (mismatches == 0) begin
            $display("rc4_keystream_generator regression: pass");
        end else begin
            $display("rc4_keystream_generator regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rc4kg_pkg.sv
sv/rc4kg_ram.sv
sv/rc4kg_ctrl.sv
sv/rc4kg_datapath.sv
sv/rc4_keystream_generator.sv
tb/sv/rc4_keystream_generator_tb.sv
